### rtl/core/dse_pkg.sv
// dse_pkg: shared types and constants of the two-stack engine.
// No dependencies; every other file in rtl/core refers to it by scoped names.
package dse_pkg;

  localparam int STACK_DEPTH_DEFAULT = 8;

  // Widest entry index the command format carries (STACK_DEPTH up to 256).
  localparam int IDX_W = 8;

  localparam int DATA_W    = 32;
  localparam int CAP_W     = 4;
  localparam int CFG_IDX_W = 2;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(8);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY_A = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY_B = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_DUMP = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  // What the back end has to do with one accepted item.
  typedef enum logic [1:0] {
    CMD_STATUS = 2'd0,   // status-only result, no store access
    CMD_WRITE  = 2'd1,   // push into the store
    CMD_READ   = 2'd2,   // pop: one read
    CMD_DUMP   = 2'd3    // read from idx down to 0
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t               kind;
    logic [1:0]              status;
    logic                    stack;
    logic [IDX_W-1:0]        idx;
    logic signed [DATA_W-1:0] data;
  } cmd_t;

endpackage

### rtl/core/dse_if.sv
// dse_if: valid/ready channel interfaces of the two-stack engine.
// Depends on dse_pkg for field widths.
interface dse_req_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       operation;
  logic                             stack_select;
  logic signed [dse_pkg::DATA_W-1:0] push_value;

  modport source (output valid, operation, stack_select, push_value, input ready);
  modport sink   (input valid, operation, stack_select, push_value, output ready);
endinterface

interface dse_rsp_if;
  logic                             valid;
  logic                             ready;
  logic signed [dse_pkg::DATA_W-1:0] data_out;
  logic [1:0]                       status;
  logic                             last;

  modport source (output valid, data_out, status, last, input ready);
  modport sink   (input valid, data_out, status, last, output ready);
endinterface

interface dse_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [dse_pkg::CFG_IDX_W-1:0]   index;
  logic [dse_pkg::CAP_W-1:0]       data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/core/dual_stack_engine.sv
// dual_stack_engine: two LIFO stacks interleaved in one store.
// Depends on dse_pkg, dse_if, dse_front, dse_cmd_queue, dse_back.
//
// Channels:
//   req  - one item: operation (push/pop/dump), stack_select, push_value.
//   rsp  - results: data_out, status, last. Push and pop give one result,
//          dump gives one per held entry top to bottom (last on the bottom
//          one), an empty dump gives a single empty-status result.
//   cfg  - capacity writes (index 0: stack 0, index 1: stack 1), always ready.
//          Other indexes are dropped. Write only while the block is idle.
// Result path (from req transfer to first rsp valid, receiver ready):
//   status-only results and pushes pass the queue and the result register;
//   pops and dumps also pass the registered read of the store.
// Throughput (receiver ready): a push or status result every cycle, a dump
//   one entry per cycle after its first read; a pop holds back the next item.
// The front accepts items into a two-entry command queue while the back end
//   works, so req.ready drops only when that queue is full.
// Reset: fill counts clear, capacities return to 8, queue and result
//   register empty. The store itself is not cleared; only pushed entries
//   are ever read.
// Stall: when rsp.ready is low the result register holds, the back end
//   waits, the queue fills and then req.ready falls.
module dual_stack_engine #(
  parameter int STACK_DEPTH = dse_pkg::STACK_DEPTH_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  dse_req_if.sink   req,
  dse_rsp_if.source rsp,
  dse_cfg_if.sink   cfg
);

  logic          q_push;
  logic          q_full;
  logic          q_pop;
  logic          q_valid;
  dse_pkg::cmd_t q_in;
  dse_pkg::cmd_t q_out;

  // Front: handshake, config, fill counts, classification.
  dse_front #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .cfg    (cfg),
    .q_push (q_push),
    .q_cmd  (q_in),
    .q_full (q_full)
  );

  // Decoupling queue so each side stalls on its own.
  dse_cmd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_cmd  (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_cmd   (q_out),
    .not_empty (q_valid)
  );

  // Back: store access and the result register.
  dse_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_cmd   (q_out),
    .q_pop   (q_pop),
    .rsp     (rsp)
  );

  // Error and empty results always close their item.
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status != dse_pkg::ST_OK) |-> rsp.last)
    else $error("error status result without last");

  // The front never pushes into a full queue.
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("command queue overrun");

  // The back end never pops an empty queue.
  a_no_underrun: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("command queue underrun");

  // An undefined operation leaves no command behind.
  a_none_dropped: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready && req.operation == dse_pkg::OP_NONE) |-> !q_push)
    else $error("undefined operation queued");

endmodule

### rtl/core/dse_cmd_queue.sv
// dse_cmd_queue: two-entry command FIFO between front and back end.
// Depends on dse_pkg (cmd_t).
module dse_cmd_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  dse_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output dse_pkg::cmd_t pop_cmd,
  output logic          not_empty
);

  dse_pkg::cmd_t entries [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign pop_cmd   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

### rtl/core/dse_front.sv
// dse_front: accepts items and config writes, tracks fill counts, classifies
// each item into a back-end command. Depends on dse_pkg and dse_if.
module dse_front #(
  parameter int STACK_DEPTH = dse_pkg::STACK_DEPTH_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  dse_req_if.sink       req,
  dse_cfg_if.sink       cfg,
  output logic          q_push,
  output dse_pkg::cmd_t q_cmd,
  input  logic          q_full
);

  localparam int CNTW = $clog2(STACK_DEPTH + 1);
  localparam int CMPW = (CNTW > dse_pkg::CAP_W) ? CNTW : dse_pkg::CAP_W;

  logic [dse_pkg::CAP_W-1:0] capacity_a;
  logic [dse_pkg::CAP_W-1:0] capacity_b;
  logic [CNTW-1:0]           fill [2];

  logic                      accept;
  logic [CNTW-1:0]           n;
  logic [CMPW-1:0]           cap_sel;
  logic [CMPW-1:0]           limit;
  logic [CNTW-1:0]           fill_next;
  logic                      fill_we;

  assign cfg.ready = 1'b1;
  assign req.ready = ~q_full;
  assign accept    = req.valid & req.ready;

  assign n       = fill[req.stack_select];
  assign cap_sel = CMPW'(req.stack_select ? capacity_b : capacity_a);
  // Capacity above the depth saturates.
  assign limit   = (cap_sel > CMPW'(STACK_DEPTH)) ? CMPW'(STACK_DEPTH) : cap_sel;

  always_comb begin
    q_cmd.kind   = dse_pkg::CMD_STATUS;
    q_cmd.status = dse_pkg::ST_OK;
    q_cmd.stack  = req.stack_select;
    q_cmd.idx    = dse_pkg::IDX_W'(n - CNTW'(1));
    q_cmd.data   = req.push_value;
    q_push       = 1'b0;
    fill_we      = 1'b0;
    fill_next    = n;
    unique case (dse_pkg::op_t'(req.operation))
      dse_pkg::OP_PUSH: begin
        q_push = accept;
        if (CMPW'(n) >= limit) begin
          q_cmd.status = dse_pkg::ST_OVERFLOW;
        end else begin
          q_cmd.kind = dse_pkg::CMD_WRITE;
          q_cmd.idx  = dse_pkg::IDX_W'(n);
          fill_we    = accept;
          fill_next  = n + CNTW'(1);
        end
      end
      dse_pkg::OP_POP: begin
        q_push = accept;
        if (n == '0) begin
          q_cmd.status = dse_pkg::ST_UNDERFLOW;
        end else begin
          q_cmd.kind = dse_pkg::CMD_READ;
          fill_we    = accept;
          fill_next  = n - CNTW'(1);
        end
      end
      dse_pkg::OP_DUMP: begin
        q_push = accept;
        if (n == '0) begin
          q_cmd.status = dse_pkg::ST_EMPTY;
        end else begin
          q_cmd.kind = dse_pkg::CMD_DUMP;
        end
      end
      dse_pkg::OP_NONE: begin
        q_push = 1'b0;   // accepted and dropped
      end
      default: begin
        q_push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill[0]    <= '0;
      fill[1]    <= '0;
      capacity_a <= dse_pkg::CAP_RESET;
      capacity_b <= dse_pkg::CAP_RESET;
    end else begin
      if (fill_we) fill[req.stack_select] <= fill_next;
      if (cfg.valid && cfg.index == dse_pkg::REG_CAPACITY_A) capacity_a <= cfg.data;
      if (cfg.valid && cfg.index == dse_pkg::REG_CAPACITY_B) capacity_b <= cfg.data;
    end
  end

endmodule

### rtl/core/dse_back.sv
// dse_back: executes commands against the shared store and drives results.
// Depends on dse_pkg and dse_if.
module dse_back #(
  parameter int STACK_DEPTH = dse_pkg::STACK_DEPTH_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  dse_pkg::cmd_t q_cmd,
  output logic          q_pop,
  dse_rsp_if.source     rsp
);

  localparam int IDXW      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int MEM_DEPTH = 2 * STACK_DEPTH;
  localparam int AW        = $clog2(MEM_DEPTH);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  logic signed [dse_pkg::DATA_W-1:0] mem [MEM_DEPTH];
  logic signed [dse_pkg::DATA_W-1:0] rdata;

  logic            rd_en;
  logic [AW-1:0]   rd_addr;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;

  logic            cur_stack;     // stack of the read in flight
  logic [IDXW-1:0] cur_idx;       // entry index of the read in flight
  logic            cur_dump;
  logic            cur_stack_next;
  logic [IDXW-1:0] cur_idx_next;
  logic            cur_dump_next;

  logic            out_free;
  logic            out_load;
  logic signed [dse_pkg::DATA_W-1:0] out_data_next;
  logic [1:0]      out_status_next;
  logic            out_last_next;
  logic [IDXW-1:0] q_idx;

  assign out_free = ~rsp.valid | rsp.ready;
  assign q_idx    = q_cmd.idx[IDXW-1:0];
  assign wr_addr  = AW'({q_idx, q_cmd.stack});

  always_comb begin
    state_next      = state;
    q_pop           = 1'b0;
    rd_en           = 1'b0;
    rd_addr         = AW'({q_idx, q_cmd.stack});
    wr_en           = 1'b0;
    out_load        = 1'b0;
    out_data_next   = '0;
    out_status_next = q_cmd.status;
    out_last_next   = 1'b1;
    cur_stack_next  = cur_stack;
    cur_idx_next    = cur_idx;
    cur_dump_next   = cur_dump;
    unique case (state)
      S_IDLE: begin
        if (q_valid) begin
          unique case (q_cmd.kind)
            dse_pkg::CMD_STATUS, dse_pkg::CMD_WRITE: begin
              if (out_free) begin
                q_pop    = 1'b1;
                out_load = 1'b1;
                wr_en    = (q_cmd.kind == dse_pkg::CMD_WRITE);
              end
            end
            dse_pkg::CMD_READ, dse_pkg::CMD_DUMP: begin
              q_pop          = 1'b1;
              rd_en          = 1'b1;
              cur_stack_next = q_cmd.stack;
              cur_idx_next   = q_idx;
              cur_dump_next  = (q_cmd.kind == dse_pkg::CMD_DUMP);
              state_next     = S_READ;
            end
            default: begin
              q_pop = 1'b0;
            end
          endcase
        end
      end
      S_READ: begin
        // rdata holds until the output slot frees up
        out_status_next = dse_pkg::ST_OK;
        out_data_next   = rdata;
        out_last_next   = ~cur_dump | (cur_idx == '0);
        if (out_free) begin
          out_load = 1'b1;
          if (cur_dump && cur_idx != '0) begin
            cur_idx_next = cur_idx - IDXW'(1);
            rd_en        = 1'b1;
            rd_addr      = AW'({cur_idx - IDXW'(1), cur_stack});
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= q_cmd.data;
    if (rd_en) rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    cur_stack <= cur_stack_next;
    cur_idx   <= cur_idx_next;
    cur_dump  <= cur_dump_next;
    if (out_load) begin
      rsp.data_out <= out_data_next;
      rsp.status   <= out_status_next;
      rsp.last     <= out_last_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load)       rsp.valid <= 1'b1;
      else if (rsp.ready) rsp.valid <= 1'b0;
    end
  end

endmodule

### verif/dual_stack_engine_test.sv
// dual_stack_engine_test: self-checking bench for the two-stack engine.
// Depends on dse_pkg, dse_if and the dual_stack_engine RTL; nothing else.
// Directed corner items, then random push/pop/dump traffic over capacity settings.
module dual_stack_engine_test;
  timeunit 1ns;
  timeprecision 1ps;

  import dse_pkg::*;

  localparam int DEPTH         = STACK_DEPTH_DEFAULT;
  localparam int SETTLE_CYCLES = 12;     // covers the registered read path plus queue
  localparam int DRAIN_LIMIT   = 20000;  // cycles to wait for outstanding results
  localparam int MAX_REPORTS   = 10;

  // Unused register slots; writes there must be dropped.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = CFG_IDX_W'(3);

  // Idling modes, one per phase.
  localparam int IDLE_NONE = 0;
  localparam int IDLE_SEND = 1;
  localparam int IDLE_RECV = 2;
  localparam int IDLE_BOTH = 3;

  typedef struct packed {
    logic signed [DATA_W-1:0] data;
    logic [1:0]               status;
    logic                     last;
  } stack_result_t;

  // Shadow of both stacks plus the queue of results still owed by the block.
  class stack_predictor;
    logic signed [DATA_W-1:0] slots [2*DEPTH];
    int unsigned              fill [2];
    logic [CAP_W-1:0]         cap [2];
    stack_result_t            owed [$];
    int                       mismatches;
    int                       checked;

    function new();
      fill       = '{0, 0};
      cap        = '{CAP_RESET, CAP_RESET};
      mismatches = 0;
      checked    = 0;
    endfunction

    function void set_capacity(logic [CFG_IDX_W-1:0] idx, logic [CAP_W-1:0] value);
      if (idx == REG_CAPACITY_A) cap[0] = value;
      else if (idx == REG_CAPACITY_B) cap[1] = value;
    endfunction

    // Capacities above the physical depth saturate.
    function int unsigned room(logic s);
      return (cap[s] > DEPTH) ? DEPTH : cap[s];
    endfunction

    function void owe(logic signed [DATA_W-1:0] data, logic [1:0] status, logic last);
      stack_result_t r;
      r.data   = data;
      r.status = status;
      r.last   = last;
      owed.push_back(r);
    endfunction

    function void note_item(op_t op, logic s, logic signed [DATA_W-1:0] value);
      int unsigned n;
      n = fill[s];
      case (op)
        OP_PUSH: begin
          if (n >= room(s)) begin
            owe('0, ST_OVERFLOW, 1'b1);
          end else begin
            slots[2*n + s] = value;
            fill[s] = n + 1;
            owe('0, ST_OK, 1'b1);
          end
        end
        OP_POP: begin
          if (n == 0) begin
            owe('0, ST_UNDERFLOW, 1'b1);
          end else begin
            fill[s] = n - 1;
            owe(slots[2*(n-1) + s], ST_OK, 1'b1);
          end
        end
        OP_DUMP: begin
          if (n == 0) begin
            owe('0, ST_EMPTY, 1'b1);
          end else begin
            for (int i = n; i > 0; i--) owe(slots[2*(i-1) + s], ST_OK, i == 1);
          end
        end
        default: ;  // undefined op: no result, no state change
      endcase
    endfunction

    function void check_result(logic signed [DATA_W-1:0] data, logic [1:0] status,
                               logic last);
      stack_result_t want;
      checked++;
      if (owed.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected result data_out=%0d status=%0d last=%0b",
                   $realtime, data, status, last);
        return;
      end
      want = owed.pop_front();
      if (data !== want.data || status !== want.status || last !== want.last) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: mismatch data_out exp %0d got %0d,", $realtime, want.data, data,
                   " status exp %0d got %0d, last exp %0b got %0b",
                   want.status, status, want.last, last);
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  dse_req_if req_ch ();
  dse_rsp_if rsp_ch ();
  dse_cfg_if cfg_ch ();

  dual_stack_engine #(.STACK_DEPTH(DEPTH)) DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  stack_predictor predictor = new();

  int  send_idle_pct  = 0;
  int  recv_stall_pct = 0;
  int  items_sent     = 0;
  int  ignored_sent   = 0;
  int  settings_run   = 0;
  bit  drain_timeout  = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Result receiver: ready toggles at the falling edge per the current stall rate.
  always @(negedge clk) begin
    rsp_ch.ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
  end

  // Every result transfer is checked against the oldest owed result.
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready)
      predictor.check_result(rsp_ch.data_out, rsp_ch.status, rsp_ch.last);
  end

  task automatic set_idling(int mode);
    send_idle_pct  = (mode == IDLE_SEND) ? 61 : (mode == IDLE_BOTH) ? 14 : 0;
    recv_stall_pct = (mode == IDLE_RECV) ? 61 : (mode == IDLE_BOTH) ? 14 : 0;
  endtask

  // Called at a falling edge; returns at a falling edge with valid possibly still
  // high, so the caller either presents the next item or releases the channel.
  task automatic send_item(op_t op, logic s, logic signed [DATA_W-1:0] value);
    req_ch.valid        <= 1'b1;
    req_ch.operation    <= op;
    req_ch.stack_select <= s;
    req_ch.push_value   <= value;
    do @(posedge clk); while (!req_ch.ready);
    predictor.note_item(op, s, value);
    items_sent++;
    if (op == OP_NONE) ignored_sent++;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
  endtask

  // Drop the request and wait until every owed result has come back, then
  // wait out SETTLE_CYCLES more before returning.
  task automatic settle();
    int guard;
    guard = 0;
    req_ch.valid <= 1'b0;
    while (predictor.owed.size() != 0 && guard < DRAIN_LIMIT) begin
      @(negedge clk);
      guard++;
    end
    if (guard >= DRAIN_LIMIT) drain_timeout = 1'b1;
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Only called with the block idle. Writes run back to back, then release.
  task automatic program_capacities(logic [CAP_W-1:0] cap_a, logic [CAP_W-1:0] cap_b,
                                    bit with_spare);
    logic [CFG_IDX_W-1:0] idx [4];
    logic [CAP_W-1:0]     val [4];
    int                   count;
    idx[0] = REG_CAPACITY_A; val[0] = cap_a;
    idx[1] = REG_CAPACITY_B; val[1] = cap_b;
    idx[2] = REG_SPARE_2;    val[2] = CAP_W'($urandom_range(15));
    idx[3] = REG_SPARE_3;    val[3] = CAP_W'($urandom_range(15));
    count  = with_spare ? 4 : 2;
    for (int k = 0; k < count; k++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= idx[k];
      cfg_ch.data  <= val[k];
      do @(posedge clk); while (!cfg_ch.ready);
      predictor.set_capacity(idx[k], val[k]);
      @(negedge clk);
    end
    cfg_ch.valid <= 1'b0;
    settings_run++;
  endtask

  // Random traffic; push_pct biases toward filling (high) or draining (low).
  // Ignored op codes ride along but do not count toward the item budget.
  task automatic run_random(int count, int push_pct);
    op_t                      op;
    logic                     s;
    logic signed [DATA_W-1:0] value;
    int unsigned              pick;
    int                       done;
    done = 0;
    while (done < count) begin
      pick = $urandom_range(99);
      if (pick < push_pct) op = OP_PUSH;
      else if (pick < 82) op = OP_POP;
      else if (pick < 96) op = OP_DUMP;
      else op = OP_NONE;
      s    = 1'($urandom_range(1));
      pick = $urandom_range(9);
      if (pick == 0) value = 32'sh7FFF_FFFF;
      else if (pick == 1) value = 32'sh8000_0000;
      else value = $urandom();
      send_item(op, s, value);
      if (op != OP_NONE) done++;
    end
  endtask

  initial begin
    logic [CAP_W-1:0] caps_a [8];
    logic [CAP_W-1:0] caps_b [8];
    caps_a = '{4'd3, 4'd8, 4'd0, 4'd15, 4'd5, 4'd8, 4'd2, 4'd8};
    caps_b = '{4'd15, 4'd8, 4'd8, 4'd1, 4'd0, 4'd12, 4'd7, 4'd8};

    rst                 = 1'b1;
    req_ch.valid        = 1'b0;
    req_ch.operation    = OP_PUSH;
    req_ch.stack_select = 1'b0;
    req_ch.push_value   = '0;
    rsp_ch.ready        = 1'b0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.index        = REG_CAPACITY_A;
    cfg_ch.data         = '0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty-stack errors, ignored op code, full fill with extreme
    // words, overflow, deep dump, pops back down to underflow.
    set_idling(IDLE_NONE);
    send_item(OP_POP,  1'b0, '0);
    send_item(OP_POP,  1'b1, '0);
    send_item(OP_DUMP, 1'b0, '0);
    send_item(OP_DUMP, 1'b1, '0);
    send_item(OP_NONE, 1'b0, 32'sh1234_5678);
    send_item(OP_NONE, 1'b1, -32'sd1);
    send_item(OP_PUSH, 1'b0, 32'sh7FFF_FFFF);
    send_item(OP_PUSH, 1'b0, 32'sh8000_0000);
    send_item(OP_PUSH, 1'b0, 32'sh0000_0000);
    send_item(OP_PUSH, 1'b0, -32'sd1);
    send_item(OP_PUSH, 1'b0, 32'shAAAA_AAAA);
    send_item(OP_PUSH, 1'b0, 32'sh5555_5555);
    send_item(OP_PUSH, 1'b0, 32'sd1);
    send_item(OP_PUSH, 1'b0, -32'sd2);
    send_item(OP_PUSH, 1'b0, 32'sh1234_5678);   // full at reset capacity
    send_item(OP_PUSH, 1'b1, 32'sh8000_0000);
    send_item(OP_PUSH, 1'b1, 32'sh7FFF_FFFF);
    send_item(OP_DUMP, 1'b0, '0);
    send_item(OP_DUMP, 1'b1, '0);
    send_item(OP_POP,  1'b0, '0);
    send_item(OP_POP,  1'b1, '0);
    send_item(OP_POP,  1'b1, '0);
    send_item(OP_POP,  1'b1, '0);               // now empty again
    send_item(OP_DUMP, 1'b1, '0);

    // Phases: the first one lowers stack 0 below its fill and raises stack 1
    // past the depth; later ones sweep zero, full and odd capacities under
    // each idling mode, alternating fill-heavy and drain-heavy traffic.
    for (int p = 0; p < 8; p++) begin
      settle();
      program_capacities(caps_a[p], caps_b[p], (p % 3) == 0);
      set_idling(p % 4);
      run_random(37, (p % 2) ? 42 : 58);
    end

    settle();
    $display("Ran %0d items (%0d with unused op code) across %0d capacity settings",
             items_sent, ignored_sent, settings_run);
    $display("Checked %0d results, %0d mismatched, %0d still owed",
             predictor.checked, predictor.mismatches, predictor.owed.size());
    if (predictor.mismatches == 0 && predictor.owed.size() == 0 && !drain_timeout) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/dse_pkg.sv
rtl/core/dse_if.sv
rtl/core/dse_cmd_queue.sv
rtl/core/dse_front.sv
rtl/core/dse_back.sv
rtl/core/dual_stack_engine.sv
verif/dual_stack_engine_test.sv
